[sv/atg_pkg.sv]
`default_nettype none

package atg_pkg;

  // Width of the two's complement template coordinates.
  localparam int COORD_WIDTH = 32;

  localparam int CHAR_WIDTH  = 8;
  localparam int POS_WIDTH   = 31;
  localparam int PREV_WIDTH  = 32;
  localparam int READ_WIDTH  = 32;
  localparam int COUNT_WIDTH = 31;
  localparam int CFG_WIDTH   = 32;
  localparam int INDEX_WIDTH = 2;

  localparam logic [CHAR_WIDTH-1:0]  GAP_CHAR    = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0]  DOT_CHAR    = 8'h2E;
  localparam logic [CHAR_WIDTH-1:0]  DEPTH_LIMIT = 8'hFF;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};

  localparam logic [INDEX_WIDTH-1:0] REG_TEMPLATE_START  = 2'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_TEMPLATE_OFFSET = 2'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_READ_ID         = 2'd2;

  localparam logic KIND_TAG      = 1'b0;
  localparam logic KIND_SENTINEL = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [POS_WIDTH-1:0]     tag_pos;
    logic [CHAR_WIDTH-1:0]    tag_depth;
    logic [CHAR_WIDTH-1:0]    tag_base;
    logic signed [PREV_WIDTH-1:0] prev_pos;
    logic [CHAR_WIDTH-1:0]    prev_depth;
    logic [CHAR_WIDTH-1:0]    prev_base;
    logic [READ_WIDTH-1:0]    tag_read;
    logic [COUNT_WIDTH-1:0]   tag_count;
    logic                     run_last;
  } result_t;

  // Results that one column pushes into the output queue.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

[sv/alignment_tag_generator.sv]
`default_nettype none

// Alignment tag generator. Each input word is one column of a pairwise
// alignment (query byte, template byte, last flag, where 0x2D marks a gap),
// and each result word is either a tag (kind 0) or an end sentinel (kind 1)
// that carries the number of tags emitted for the alignment. A column yields
// one tag, or a sentinel when tagging stops early, and the last column adds
// the closing sentinel and rearms the block; columns after an early stop
// yield nothing, the last one included. An input word is captured in an input
// register, worked on once the output queue has room for both possible results
// and its results are written into that four-entry queue, so a column is taken
// every clock cycle as long as results are drained at the same pace; the queue's
// single read port limits the output to one word per cycle, so the two words of
// a column that makes two leave one after the other. Configuration registers
// are written through the plain write port and take effect for the next column;
// they should only be written while no column is in flight.
module alignment_tag_generator import atg_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CHAR_WIDTH-1:0]    query_char,
  input  wire logic [CHAR_WIDTH-1:0]    template_char,
  input  wire logic                     column_last,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          kind,
  output logic [POS_WIDTH-1:0]          tag_pos,
  output logic [CHAR_WIDTH-1:0]         tag_depth,
  output logic [CHAR_WIDTH-1:0]         tag_base,
  output logic signed [PREV_WIDTH-1:0]  prev_pos,
  output logic [CHAR_WIDTH-1:0]         prev_depth,
  output logic [CHAR_WIDTH-1:0]         prev_base,
  output logic [READ_WIDTH-1:0]         tag_read,
  output logic [COUNT_WIDTH-1:0]        tag_count,
  output logic                          run_last
);

  // Input register: one captured column waiting for queue room.
  logic                  in_full;
  logic [CHAR_WIDTH-1:0] in_query;
  logic [CHAR_WIDTH-1:0] in_template;
  logic                  in_last;

  logic    room;
  logic    step;
  logic    accept;
  push_t   push;
  result_t head;

  // The held column moves on whenever the queue can take both of its
  // possible results; a new column can be captured in that same cycle.
  assign step     = in_full && room;
  assign in_stall = in_full && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_query    <= query_char;
      in_template <= template_char;
      in_last     <= column_last;
    end
  end

  atg_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .step          (step),
    .query_char    (in_query),
    .template_char (in_template),
    .column_last   (in_last),
    .push          (push)
  );

  atg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .pop        (!out_stall),
    .head_valid (out_valid),
    .head       (head)
  );

  // The queue head drives the result word directly.
  assign kind       = head.kind;
  assign tag_pos    = head.tag_pos;
  assign tag_depth  = head.tag_depth;
  assign tag_base   = head.tag_base;
  assign prev_pos   = head.prev_pos;
  assign prev_depth = head.prev_depth;
  assign prev_base  = head.prev_base;
  assign tag_read   = head.tag_read;
  assign tag_count  = head.tag_count;
  assign run_last   = head.run_last;

endmodule

`default_nettype wire

[sv/atg_core.sv]
`default_nettype none

module atg_core import atg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]   cfg_data,
  input  wire logic                   step,
  input  wire logic [CHAR_WIDTH-1:0]  query_char,
  input  wire logic [CHAR_WIDTH-1:0]  template_char,
  input  wire logic                   column_last,
  output push_t                       push
);

  logic [POS_WIDTH-1:0]   template_start;
  logic [CFG_WIDTH-1:0]   template_offset;
  logic [READ_WIDTH-1:0]  read_id;

  logic [COORD_WIDTH-1:0] template_pos;
  logic [CHAR_WIDTH-1:0]  insert_depth;
  logic [COORD_WIDTH-1:0] last_template_pos;
  logic [CHAR_WIDTH-1:0]  last_depth;
  logic [CHAR_WIDTH-1:0]  last_query_base;
  logic                   stopped;
  logic [COUNT_WIDTH-1:0] emitted_count;

  logic [COORD_WIDTH-1:0] start_pos;
  logic [COORD_WIDTH-1:0] offset_ext;
  logic [COORD_WIDTH-1:0] pos_base;
  logic [COORD_WIDTH-1:0] pos_new;
  logic [CHAR_WIDTH-1:0]  depth_new;
  logic [COORD_WIDTH-1:0] sum;
  logic [COORD_WIDTH-1:0] prev_sum;
  logic                   tag_ok;
  logic [COUNT_WIDTH-1:0] count_inc;
  result_t                tag_res;
  result_t                end_res;
  result_t                end_inc_res;

  assign start_pos  = COORD_WIDTH'({{COORD_WIDTH{1'b0}}, template_start})
                      - COORD_WIDTH'(1);
  assign offset_ext = COORD_WIDTH'({{COORD_WIDTH{template_offset[CFG_WIDTH-1]}},
                                    template_offset});
  assign pos_base   = (emitted_count == '0) ? start_pos : template_pos;

  always_comb begin
    pos_new   = pos_base;
    depth_new = insert_depth;
    if (query_char != GAP_CHAR && insert_depth != DEPTH_LIMIT) begin
      depth_new = insert_depth + 8'd1;
    end
    if (template_char != GAP_CHAR) begin
      pos_new   = pos_base + COORD_WIDTH'(1);
      depth_new = '0;
    end
  end

  assign sum       = pos_new + offset_ext;
  assign prev_sum  = last_template_pos + offset_ext;
  assign tag_ok    = !sum[COORD_WIDTH-1] && depth_new != DEPTH_LIMIT
                     && last_depth != DEPTH_LIMIT;
  assign count_inc = (emitted_count != COUNT_MAX) ? emitted_count + COUNT_WIDTH'(1)
                                                  : emitted_count;

  always_comb begin
    tag_res.kind       = KIND_TAG;
    tag_res.tag_pos    = POS_WIDTH'(sum);
    tag_res.tag_depth  = depth_new;
    tag_res.tag_base   = query_char;
    tag_res.prev_pos   = PREV_WIDTH'(prev_sum);
    tag_res.prev_depth = last_depth;
    tag_res.prev_base  = last_query_base;
    tag_res.tag_read   = read_id;
    tag_res.tag_count  = '0;
    tag_res.run_last   = !column_last;

    end_res.kind       = KIND_SENTINEL;
    end_res.tag_pos    = '0;
    end_res.tag_depth  = DEPTH_LIMIT;
    end_res.tag_base   = DOT_CHAR;
    end_res.prev_pos   = '0;
    end_res.prev_depth = '0;
    end_res.prev_base  = '0;
    end_res.tag_read   = {READ_WIDTH{1'b1}};
    end_res.tag_count  = emitted_count;
    end_res.run_last   = 1'b1;

    end_inc_res           = end_res;
    end_inc_res.tag_count = count_inc;
  end

  always_comb begin
    push.push0 = step && !stopped;
    push.push1 = step && !stopped && tag_ok && column_last;
    push.res0  = tag_ok ? tag_res : end_res;
    push.res1  = end_inc_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      template_start  <= '0;
      template_offset <= '0;
      read_id         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMPLATE_START:  template_start  <= cfg_data[POS_WIDTH-1:0];
        REG_TEMPLATE_OFFSET: template_offset <= cfg_data;
        REG_READ_ID:         read_id         <= cfg_data[READ_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && column_last)) begin
      // Reset and the last column both rearm for the next alignment.
      template_pos      <= rst ? {COORD_WIDTH{1'b1}} : start_pos;
      insert_depth      <= '0;
      last_template_pos <= {COORD_WIDTH{1'b1}};
      last_depth        <= '0;
      last_query_base   <= DOT_CHAR;
      stopped           <= 1'b0;
      emitted_count     <= '0;
    end else if (step && !stopped) begin
      template_pos <= pos_new;
      insert_depth <= depth_new;
      if (tag_ok) begin
        last_template_pos <= pos_new;
        last_depth        <= depth_new;
        last_query_base   <= query_char;
        emitted_count     <= count_inc;
      end else begin
        stopped <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/atg_queue.sv]
`default_nettype none

module atg_queue import atg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  input  wire logic  pop,
  output logic       head_valid,
  output result_t    head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  result_t            store [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W:0]     count;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [PTR_W:0]     count_next;
  logic               do_pop;

  // Room for two results, whatever the head does this cycle.
  assign room       = count <= (PTR_W + 1)'(DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = store[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.push0) + PTR_W'(push.push1);
    count_next  = count + (PTR_W + 1)'(push.push0) + (PTR_W + 1)'(push.push1)
                  - (PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      store[wr_ptr] <= push.res0;
    end
    if (push.push1) begin
      store[wr_ptr + PTR_W'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sim/tb_alignment_tag_generator.sv]
module tb_alignment_tag_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import atg_pkg::*;

  // The register map has four slots; the last one is unused and a write to it
  // must leave every register untouched.
  localparam logic [INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  // Cycles allowed after the last expected word arrives. A column that makes
  // no word can still sit in the input register at that point.
  localparam int DRAIN_SLACK = 8;

  // Slowest correct run: every column waits out the longest sender gap and up
  // to two words, each waiting out the longest stall. Even then this limit
  // leaves a wide margin.
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                        clk;
  logic                        rst           = 1'b1;
  logic                        cfg_write     = 1'b0;
  logic [INDEX_WIDTH-1:0]      cfg_index     = '0;
  logic [CFG_WIDTH-1:0]        cfg_data      = '0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [CHAR_WIDTH-1:0]       query_char    = '0;
  logic [CHAR_WIDTH-1:0]       template_char = '0;
  logic                        column_last   = 1'b0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic                        kind;
  logic [POS_WIDTH-1:0]        tag_pos;
  logic [CHAR_WIDTH-1:0]       tag_depth;
  logic [CHAR_WIDTH-1:0]       tag_base;
  logic signed [PREV_WIDTH-1:0] prev_pos;
  logic [CHAR_WIDTH-1:0]       prev_depth;
  logic [CHAR_WIDTH-1:0]       prev_base;
  logic [READ_WIDTH-1:0]       tag_read;
  logic [COUNT_WIDTH-1:0]      tag_count;
  logic                        run_last;

  alignment_tag_generator u_dut (
    .clk,
    .rst,
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_stall,
    .query_char,
    .template_char,
    .column_last,
    .out_valid,
    .out_stall,
    .kind,
    .tag_pos,
    .tag_depth,
    .tag_base,
    .prev_pos,
    .prev_depth,
    .prev_base,
    .tag_read,
    .tag_count,
    .run_last
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Our own copy of the configuration registers, updated as they are written.
  logic [POS_WIDTH-1:0]        start_cfg  = '0;
  logic signed [31:0]          offset_cfg = '0;
  logic [READ_WIDTH-1:0]       read_cfg   = '0;

  // Our own copy of the tracking state: the current template position and
  // insertion depth, the fields of the last tag sent, whether tagging stopped
  // early in this alignment, and how many tags the alignment has produced.
  logic [COORD_WIDTH-1:0]      pos_now;
  logic [CHAR_WIDTH-1:0]       depth_now;
  logic [COORD_WIDTH-1:0]      pos_prev;
  logic [CHAR_WIDTH-1:0]       depth_prev;
  logic [CHAR_WIDTH-1:0]       base_prev;
  logic                        halted;
  logic [COUNT_WIDTH-1:0]      tags_sent;

  // Words the block still owes us, oldest first.
  result_t expected_tags[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Chance in percent that an idle burst starts, per column on the input side
  // and per cycle on the output side. Zero turns the idling off.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Back to the state at the start of an alignment. The position is reloaded
  // again at the first column, so a start written in between still counts.
  task automatic rearm_tracker;
    pos_now    = COORD_WIDTH'(start_cfg) - 1'b1;
    depth_now  = '0;
    pos_prev   = '1;
    depth_prev = '0;
    base_prev  = DOT_CHAR;
    halted     = 1'b0;
    tags_sent  = '0;
  endtask

  // The closing word of an alignment; only the count carries information.
  function automatic result_t end_marker();
    result_t w;
    w            = '0;
    w.kind       = KIND_SENTINEL;
    w.tag_depth  = DEPTH_LIMIT;
    w.tag_base   = DOT_CHAR;
    w.tag_read   = '1;
    w.tag_count  = tags_sent;
    w.run_last   = 1'b1;
    return w;
  endfunction

  // Works out the words that one accepted column produces and queues them.
  task automatic predict_tags(input logic [CHAR_WIDTH-1:0] q, input logic [CHAR_WIDTH-1:0] t,
                              input logic last);
    logic [COORD_WIDTH-1:0] off;
    logic [COORD_WIDTH-1:0] sum;
    logic [COORD_WIDTH-1:0] prev_sum;
    result_t                w;
    // The offset register is 32 bits and signed; it is sign-extended to the
    // coordinate width and every sum wraps at that width.
    off = COORD_WIDTH'(offset_cfg);
    if (halted) begin
      // After an early stop the alignment already has its sentinel, so the
      // remaining columns are swallowed and the last one only rearms.
      if (last) rearm_tracker();
      return;
    end
    if (tags_sent == 0) pos_now = COORD_WIDTH'(start_cfg) - 1'b1;
    if (q != GAP_CHAR && depth_now < DEPTH_LIMIT) depth_now++;
    if (t != GAP_CHAR) begin
      pos_now   = pos_now + 1'b1;
      depth_now = '0;
    end
    sum = pos_now + off;
    if (!sum[COORD_WIDTH-1] && depth_now < DEPTH_LIMIT && depth_prev < DEPTH_LIMIT) begin
      prev_sum     = pos_prev + off;
      w            = '0;
      w.kind       = KIND_TAG;
      w.tag_pos    = POS_WIDTH'(sum);
      w.tag_depth  = depth_now;
      w.tag_base   = q;
      w.prev_pos   = PREV_WIDTH'(prev_sum);
      w.prev_depth = depth_prev;
      w.prev_base  = base_prev;
      w.tag_read   = read_cfg;
      w.run_last   = !last;
      expected_tags.push_back(w);
      pos_prev   = pos_now;
      depth_prev = depth_now;
      base_prev  = q;
      if (tags_sent < COUNT_MAX) tags_sent++;
      if (last) begin
        expected_tags.push_back(end_marker());
        rearm_tracker();
      end
    end else begin
      // A negative coordinate or a full insertion depth ends tagging early.
      expected_tags.push_back(end_marker());
      halted = 1'b1;
      if (last) rearm_tracker();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // Every word taken from the block is compared with the oldest expectation.
  always @(posedge clk) begin : check_tags
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {kind, tag_pos, tag_depth, tag_base, prev_pos, prev_depth, prev_base,
             tag_read, tag_count, run_last};
      if (expected_tags.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t ns: word %h arrived with nothing expected", $time, got);
      end else begin
        want = expected_tags.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", want.kind, got.kind);
        if (got.tag_pos !== want.tag_pos) report_mismatch("tag_pos", want.tag_pos, got.tag_pos);
        if (got.tag_depth !== want.tag_depth)
          report_mismatch("tag_depth", want.tag_depth, got.tag_depth);
        if (got.tag_base !== want.tag_base)
          report_mismatch("tag_base", want.tag_base, got.tag_base);
        if (got.prev_pos !== want.prev_pos)
          report_mismatch("prev_pos", want.prev_pos, got.prev_pos);
        if (got.prev_depth !== want.prev_depth)
          report_mismatch("prev_depth", want.prev_depth, got.prev_depth);
        if (got.prev_base !== want.prev_base)
          report_mismatch("prev_base", want.prev_base, got.prev_base);
        if (got.tag_read !== want.tag_read)
          report_mismatch("tag_read", want.tag_read, got.tag_read);
        if (got.tag_count !== want.tag_count)
          report_mismatch("tag_count", want.tag_count, got.tag_count);
        if (got.run_last !== want.run_last)
          report_mismatch("run_last", want.run_last, got.run_last);
      end
    end
  end

  // Output back-pressure comes in bursts that start at random, with the chance set by stall_pct.
  always @(negedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct)
      stall_left = $urandom_range(1, 18);
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_tags.size());
      $display("tb_alignment_tag_generator: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Writes one register. Only called while nothing is in flight, so our copy
  // can take the new value at once.
  task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_TEMPLATE_START:  start_cfg  = data[POS_WIDTH-1:0];
      REG_TEMPLATE_OFFSET: offset_cfg = data;
      REG_READ_ID:         read_cfg   = data;
      default: ;
    endcase
  endtask

  // Offers one column and holds it until the block takes it. An idle burst may
  // come first; otherwise valid stays high straight into the new word.
  task automatic send_column(input logic [CHAR_WIDTH-1:0] q, input logic [CHAR_WIDTH-1:0] t,
                             input logic last);
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid      = 1'b1;
    query_char    = q;
    template_char = t;
    column_last   = last;
    do @(posedge clk); while (in_stall);
    predict_tags(q, t, last);
  endtask

  // Drops valid, waits for every expected word, then lets a column that makes
  // no word clear the pipeline before anything else happens.
  task automatic wait_idle;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_tags.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // A column of a plausible alignment: mostly matches, then insertions,
  // deletions and double gaps. A noisy column is two arbitrary bytes.
  task automatic pick_column(output logic [CHAR_WIDTH-1:0] q, output logic [CHAR_WIDTH-1:0] t,
                             input logic noisy);
    int unsigned r;
    r = $urandom_range(0, 99);
    q = CHAR_WIDTH'($urandom_range(0, 255));
    t = CHAR_WIDTH'($urandom_range(0, 255));
    if (!noisy) begin
      if (r >= 92) begin
        q = GAP_CHAR;
        t = GAP_CHAR;
      end else if (r >= 80)
        q = GAP_CHAR;
      else if (r >= 60)
        t = GAP_CHAR;
    end
  endtask

  task automatic send_alignment(input int len, input logic noisy);
    int i;
    logic [CHAR_WIDTH-1:0] q;
    logic [CHAR_WIDTH-1:0] t;
    for (i = 0; i < len; i++) begin
      pick_column(q, t, noisy);
      send_column(q, t, i == len - 1);
    end
  endtask

  // A matched column, then a run of insertions, then ordinary columns. The
  // final column carries the last flag.
  task automatic send_insertion_alignment(input int run, input int tail);
    int i;
    logic [CHAR_WIDTH-1:0] q;
    logic [CHAR_WIDTH-1:0] t;
    send_column(8'h41, 8'h43, 1'b0);
    for (i = 0; i < run; i++) begin
      do q = CHAR_WIDTH'($urandom_range(0, 255)); while (q == GAP_CHAR);
      send_column(q, GAP_CHAR, tail == 0 && i == run - 1);
    end
    for (i = 0; i < tail; i++) begin
      pick_column(q, t, 1'b0);
      send_column(q, t, i == tail - 1);
    end
  endtask

  // Picks new register values and idling rates for a phase. Most settings keep
  // positions positive so alignments run deep; the rest push the coordinate
  // sum across the sign boundary or start out negative.
  task automatic choose_settings(input logic allow_idle);
    logic [CFG_WIDTH-1:0] start_val;
    logic [CFG_WIDTH-1:0] off_val;
    logic [CFG_WIDTH-1:0] read_val;
    case ($urandom_range(0, 9))
      6:       start_val = '0;
      7:       start_val = 32'h7FFF_FFFF - $urandom_range(0, 40);
      8:       start_val = $urandom;
      9:       start_val = $urandom_range(1, 32'h4000_0000);
      default: start_val = $urandom_range(1, 5000);
    endcase
    case ($urandom_range(0, 9))
      4, 5:    off_val = $urandom_range(0, 2000) - 1000;
      6:       off_val = 32'h8000_0000;
      7:       off_val = 32'h7FFF_FFFF - $urandom_range(0, 40);
      8:       off_val = $urandom;
      // Puts the first positions right around zero.
      9:       off_val = $urandom_range(0, 10) - 5 - {1'b0, start_val[POS_WIDTH-1:0]};
      default: off_val = '0;
    endcase
    case ($urandom_range(0, 5))
      0:       read_val = '0;
      1:       read_val = '1;
      default: read_val = $urandom;
    endcase
    write_reg(REG_TEMPLATE_START, start_val);
    write_reg(REG_TEMPLATE_OFFSET, off_val);
    write_reg(REG_READ_ID, read_val);
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
    if (allow_idle) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked columns: each column type, a one-column alignment, an early
  // stop on a negative position with swallowed columns after it, an early stop
  // on the last column, and the sign boundary of the coordinate sum reached
  // from both extremes of the start and offset registers.
  task automatic test_directed;
    gap_pct   = 0;
    stall_pct = 0;

    // Start at template position zero with the read id all ones.
    write_reg(REG_TEMPLATE_START, 32'd1);
    write_reg(REG_TEMPLATE_OFFSET, 32'd0);
    write_reg(REG_READ_ID, 32'hFFFF_FFFF);
    send_column(8'h41, 8'h41, 1'b0);       // match; first tag sees the dot
    send_column(8'h43, GAP_CHAR, 1'b0);    // insertion raises the depth
    send_column(GAP_CHAR, 8'h47, 1'b0);    // deletion moves the position
    send_column(GAP_CHAR, GAP_CHAR, 1'b0); // double gap changes nothing
    send_column(8'hFF, 8'h00, 1'b0);
    send_column(8'h00, 8'hFF, 1'b1);       // tag followed by the sentinel
    send_column(8'h54, 8'h54, 1'b1);       // alignment of a single column
    wait_idle();

    // A start of zero puts the first gap column at minus one.
    write_reg(REG_TEMPLATE_START, 32'd0);
    write_reg(REG_READ_ID, 32'd0);
    send_column(8'h41, GAP_CHAR, 1'b0);
    send_column(8'h41, 8'h41, 1'b0);
    send_column(8'h41, 8'h41, 1'b1);
    send_column(8'h41, GAP_CHAR, 1'b1);
    wait_idle();

    // Highest start: the first position is the largest positive value and
    // the next one wraps negative.
    write_reg(REG_TEMPLATE_START, 32'h7FFF_FFFF);
    send_column(8'h41, 8'h41, 1'b0);
    send_column(8'h41, 8'h41, 1'b0);
    send_column(8'h41, 8'h41, 1'b1);
    wait_idle();

    // Most negative offset: minus one plus it wraps to the largest positive
    // sum, and the next position lands on the sign bit.
    write_reg(REG_TEMPLATE_START, 32'd0);
    write_reg(REG_TEMPLATE_OFFSET, 32'h8000_0000);
    send_column(8'h41, GAP_CHAR, 1'b0);
    send_column(8'h41, 8'h41, 1'b1);
    wait_idle();

    // Largest offset from position zero: the first step already lands on the sign bit.
    write_reg(REG_TEMPLATE_START, 32'd1);
    write_reg(REG_TEMPLATE_OFFSET, 32'h7FFF_FFFF);
    send_column(8'h41, 8'h41, 1'b0);
    send_column(8'h41, 8'h41, 1'b1);
    wait_idle();

    // An offset of minus one gives a tag position of one and a negative previous
    // position; the unused register slot is written on the way.
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_TEMPLATE_START, 32'h8000_0002);
    write_reg(REG_TEMPLATE_OFFSET, 32'hFFFF_FFFF);
    write_reg(REG_READ_ID, $urandom);
    send_column(8'h41, 8'h41, 1'b1);
    wait_idle();
  endtask

  // Random alignments in phases, each phase with its own registers and idling.
  task automatic test_random_alignments;
    int unsigned columns;
    int          len;
    columns = 0;
    while (columns < 250) begin
      choose_settings(1'b1);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 7) == 0)
          len = $urandom_range(31, 80);
        else
          len = $urandom_range(1, 30);
        send_alignment(len, $urandom_range(0, 9) == 0);
        columns += len;
      end
      wait_idle();
    end
  endtask

  // Long insertion runs take the depth to 254, where tags still go out, and
  // on to 255, where tagging stops, once in the middle of an alignment and
  // once on its last column.
  task automatic test_deep_insertion;
    write_reg(REG_TEMPLATE_START, $urandom_range(1, 1000));
    write_reg(REG_TEMPLATE_OFFSET, $urandom_range(0, 1000));
    write_reg(REG_READ_ID, $urandom);
    gap_pct   = 10;
    stall_pct = 10;
    send_insertion_alignment(254, 3);
    send_insertion_alignment(255, 0);
    send_insertion_alignment(260, 1);
    wait_idle();
  endtask

  // The closing stretch runs at full rate on both sides.
  task automatic test_steady_stream;
    repeat (2) begin
      choose_settings(1'b0);
      repeat ($urandom_range(3, 6)) send_alignment($urandom_range(5, 30), 1'b0);
      wait_idle();
    end
  endtask

  initial begin
    rearm_tracker();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_alignments();
    test_deep_insertion();
    test_steady_stream();

    wait_idle();
    if (mismatch_count == 0 && expected_tags.size() == 0)
      $display("tb_alignment_tag_generator: PASS");
    else
      $display("tb_alignment_tag_generator: FAIL");
    $finish;
  end

endmodule
